// ===== src/ppns_pkg.sv =====
// Shared types and constants for the polyline nearest-segment block.
// No dependencies.
package ppns_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_W      = 16;
  localparam int VERT_W       = 3 * COORD_W;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int OPER_W       = 19;
  localparam int PROD_W       = 2 * OPER_W;
  localparam int ACC_W        = 36;
  localparam int NUM_W        = 2 * ACC_W;
  localparam int HALF_W       = 18;
  localparam int DIST_W       = 34;
  localparam int SEG_W        = 6;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int DIV_STEPS    = ACC_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_D0, MOP_D1, MOP_D2,
    MOP_M0, MOP_M1, MOP_M2,
    MOP_V0, MOP_V1, MOP_V2,
    MOP_W0, MOP_W1, MOP_W2,
    MOP_SQ_LL, MOP_SQ_HL, MOP_SQ_HH
  } mop_t;

  typedef struct packed {
    logic             ld_p;
    logic             cap_a;
    logic             cap_b;
    logic             adv_ab;
    logic             mac_clr;
    mop_t             mop;
    logic             div_step;
    logic             fin;
    logic             upd;
    logic             first;
    logic [SEG_W-1:0] seg;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic d_le0;
    logic d_ge_m;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/ppns_if.sv =====
// Channel interfaces: query/load input, result output and configuration write.
// Depends on ppns_pkg.
interface ppns_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ppns_pkg::IDX_W-1:0]   vertex_index;
  ppns_pkg::coord_t             coord_x;
  ppns_pkg::coord_t             coord_y;
  ppns_pkg::coord_t             coord_z;
  modport source(output valid, mode, vertex_index, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, mode, vertex_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface ppns_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppns_pkg::DIST_W-1:0]  min_sq_distance;
  logic [ppns_pkg::SEG_W-1:0]   seg_index;
  modport source(output valid, min_sq_distance, seg_index, input ready);
  modport sink(input valid, min_sq_distance, seg_index, output ready);
endinterface

interface ppns_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppns_pkg::CNT_W-1:0]   vertex_count;
  modport source(output valid, vertex_count, input ready);
  modport sink(input valid, vertex_count, output ready);
endinterface

// ===== src/ppns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppns_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ppns_ctrl.sv =====
// Sequencer: handshakes, vertex count register, store addressing, segment walk.
// Depends on ppns_pkg.
module ppns_ctrl #(
  parameter int MAX_VERTICES = ppns_pkg::MAX_VERTICES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_mode,
  input  logic [ppns_pkg::IDX_W-1:0]      in_vertex_index,
  output logic                            in_ready,
  input  logic                            cfg_valid,
  input  logic [ppns_pkg::CNT_W-1:0]      cfg_vertex_count,
  output logic                            cfg_ready,
  output logic                            ram_we,
  output logic [$clog2(MAX_VERTICES)-1:0] ram_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0] ram_raddr,
  output ppns_pkg::cmd_t                  cmd,
  input  ppns_pkg::sts_t                  sts
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = ($clog2(MAX_VERTICES + 1) > ppns_pkg::CNT_W) ?
                      $clog2(MAX_VERTICES + 1) : ppns_pkg::CNT_W;
  localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);
  localparam logic [NW-1:0] NMIN = NW'(2);
  localparam logic [NW-1:0] NONE = NW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_CAPA, S_RDB, S_CAPB, S_MAC, S_DRAIN, S_CHK,
    S_SQ, S_SQDR, S_DIV, S_FIN, S_UPD, S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ppns_pkg::CNT_W-1:0]      vc_r, vc_nxt;
  logic [NW-1:0]                   j_r, j_nxt;
  ppns_pkg::mop_t                  op_r, op_nxt;
  logic [ppns_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NW-1:0]                   vc_ext, eff;

  assign vc_ext    = NW'(vc_r);
  assign eff       = (vc_ext < NMIN) ? NMIN : ((vc_ext > NMAX) ? NMAX : vc_ext);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign ram_we    = in_valid && in_ready && !in_mode &&
                     (32'(in_vertex_index) < 32'(MAX_VERTICES));
  assign ram_waddr = AW'(in_vertex_index);
  assign ram_raddr = (state_r == S_RDA) ? '0 : AW'(j_r);

  always_comb begin
    state_nxt    = state_r;
    vc_nxt       = cfg_valid ? cfg_vertex_count : vc_r;
    j_nxt        = j_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mop      = ppns_pkg::MOP_NONE;
    cmd.seg      = ppns_pkg::SEG_W'(j_r - NONE);
    cmd.first    = (j_r == NONE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_mode) begin
          cmd.ld_p  = 1'b1;
          j_nxt     = NONE;
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_CAPA;
      S_CAPA: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_CAPB;
      end
      S_RDB: state_nxt = S_CAPB;
      S_CAPB: begin
        cmd.cap_b   = 1'b1;
        cmd.mac_clr = 1'b1;
        op_nxt      = ppns_pkg::MOP_D0;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mop = op_r;
        if (op_r == ppns_pkg::MOP_W2) begin
          state_nxt = S_DRAIN;
        end else begin
          op_nxt = ppns_pkg::mop_t'(op_r + 4'd1);
        end
      end
      S_DRAIN: state_nxt = S_CHK;
      S_CHK: begin
        if (!sts.d_le0 && !sts.d_ge_m) begin
          op_nxt    = ppns_pkg::MOP_SQ_LL;
          state_nxt = S_SQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SQ: begin
        cmd.mop = op_r;
        if (op_r == ppns_pkg::MOP_SQ_HH) begin
          state_nxt = S_SQDR;
        end else begin
          op_nxt = ppns_pkg::mop_t'(op_r + 4'd1);
        end
      end
      S_SQDR: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == ppns_pkg::DIV_CNT_W'(ppns_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if ((j_r + NONE) < eff) begin
          cmd.adv_ab = 1'b1;
          j_nxt      = j_r + NONE;
          state_nxt  = S_RDB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vc_r    <= ppns_pkg::CNT_W'(2);
      j_r     <= NONE;
      op_r    <= ppns_pkg::MOP_NONE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vc_r    <= vc_nxt;
      j_r     <= j_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/ppns_dp.sv =====
// Datapath: shared multiply-accumulate, restoring divider, minimum tracking, result register.
// Depends on ppns_pkg.
module ppns_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppns_pkg::cmd_t                 cmd,
  output ppns_pkg::sts_t                 sts,
  input  ppns_pkg::coord_t               in_x,
  input  ppns_pkg::coord_t               in_y,
  input  ppns_pkg::coord_t               in_z,
  input  logic [ppns_pkg::VERT_W-1:0]    ram_rdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ppns_pkg::DIST_W-1:0]    out_dist,
  output logic [ppns_pkg::SEG_W-1:0]     out_seg
);

  localparam int CW = ppns_pkg::COORD_W;
  localparam int AW = ppns_pkg::ACC_W;
  localparam int NW = ppns_pkg::NUM_W;
  localparam int HW = ppns_pkg::HALF_W;
  localparam int OW = ppns_pkg::OPER_W;

  ppns_pkg::coord_t p_r [3];
  ppns_pkg::coord_t a_r [3];
  ppns_pkg::coord_t b_r [3];
  ppns_pkg::diff_t  v [3];
  ppns_pkg::diff_t  e [3];
  ppns_pkg::diff_t  w [3];

  logic signed [OW-1:0]              opa, opb;
  logic signed [ppns_pkg::PROD_W-1:0] prod, prod_r;
  ppns_pkg::mop_t                    tag_r;
  logic [AW-1:0]                     d_r, m_r, vv_r, ww_r, dist_r, best_r, q;
  logic [NW-1:0]                     num_r, num_div;
  logic [AW:0]                       rem2;
  logic                              qbit;
  logic [ppns_pkg::SEG_W-1:0]        bseg_r;
  logic                              out_valid_r;
  logic [ppns_pkg::DIST_W-1:0]       out_dist_r;
  logic [ppns_pkg::SEG_W-1:0]        out_seg_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c] = ppns_pkg::DIFF_W'(p_r[c]) - ppns_pkg::DIFF_W'(a_r[c]);
      e[c] = ppns_pkg::DIFF_W'(b_r[c]) - ppns_pkg::DIFF_W'(a_r[c]);
      w[c] = ppns_pkg::DIFF_W'(p_r[c]) - ppns_pkg::DIFF_W'(b_r[c]);
    end
  end

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.mop)
      ppns_pkg::MOP_D0:    begin opa = OW'(v[0]); opb = OW'(e[0]); end
      ppns_pkg::MOP_D1:    begin opa = OW'(v[1]); opb = OW'(e[1]); end
      ppns_pkg::MOP_D2:    begin opa = OW'(v[2]); opb = OW'(e[2]); end
      ppns_pkg::MOP_M0:    begin opa = OW'(e[0]); opb = OW'(e[0]); end
      ppns_pkg::MOP_M1:    begin opa = OW'(e[1]); opb = OW'(e[1]); end
      ppns_pkg::MOP_M2:    begin opa = OW'(e[2]); opb = OW'(e[2]); end
      ppns_pkg::MOP_V0:    begin opa = OW'(v[0]); opb = OW'(v[0]); end
      ppns_pkg::MOP_V1:    begin opa = OW'(v[1]); opb = OW'(v[1]); end
      ppns_pkg::MOP_V2:    begin opa = OW'(v[2]); opb = OW'(v[2]); end
      ppns_pkg::MOP_W0:    begin opa = OW'(w[0]); opb = OW'(w[0]); end
      ppns_pkg::MOP_W1:    begin opa = OW'(w[1]); opb = OW'(w[1]); end
      ppns_pkg::MOP_W2:    begin opa = OW'(w[2]); opb = OW'(w[2]); end
      ppns_pkg::MOP_SQ_LL: begin opa = {1'b0, d_r[HW-1:0]};  opb = {1'b0, d_r[HW-1:0]}; end
      ppns_pkg::MOP_SQ_HL: begin opa = {1'b0, d_r[AW-1:HW]}; opb = {1'b0, d_r[HW-1:0]}; end
      ppns_pkg::MOP_SQ_HH: begin opa = {1'b0, d_r[AW-1:HW]}; opb = {1'b0, d_r[AW-1:HW]}; end
      default:             begin opa = '0; opb = '0; end
    endcase
  end

  assign prod = opa * opb;

  // one restoring step: remainder in the upper half, quotient shifts into the lower
  assign rem2    = {num_r[NW-1:AW], num_r[AW-1]};
  assign qbit    = (rem2 >= {1'b0, m_r});
  assign num_div = {(qbit ? AW'(rem2 - {1'b0, m_r}) : rem2[AW-1:0]), num_r[AW-2:0], qbit};
  assign q       = num_r[AW-1:0];

  assign sts.d_le0    = d_r[AW-1] || (d_r == '0);
  assign sts.d_ge_m   = !d_r[AW-1] && (d_r >= m_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.ld_p) begin
      p_r[0] <= in_x;
      p_r[1] <= in_y;
      p_r[2] <= in_z;
    end
    if (cmd.cap_a) begin
      a_r[0] <= ram_rdata[3*CW-1:2*CW];
      a_r[1] <= ram_rdata[2*CW-1:CW];
      a_r[2] <= ram_rdata[CW-1:0];
    end else if (cmd.adv_ab) begin
      a_r <= b_r;
    end
    if (cmd.cap_b) begin
      b_r[0] <= ram_rdata[3*CW-1:2*CW];
      b_r[1] <= ram_rdata[2*CW-1:CW];
      b_r[2] <= ram_rdata[CW-1:0];
    end
    prod_r <= prod;
    if (cmd.mac_clr) begin
      d_r   <= '0;
      m_r   <= '0;
      vv_r  <= '0;
      ww_r  <= '0;
      num_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_div;
    end else begin
      case (tag_r) inside
        ppns_pkg::MOP_D0, ppns_pkg::MOP_D1, ppns_pkg::MOP_D2: d_r  <= d_r + AW'(prod_r);
        ppns_pkg::MOP_M0, ppns_pkg::MOP_M1, ppns_pkg::MOP_M2: m_r  <= m_r + AW'(prod_r);
        ppns_pkg::MOP_V0, ppns_pkg::MOP_V1, ppns_pkg::MOP_V2: vv_r <= vv_r + AW'(prod_r);
        ppns_pkg::MOP_W0, ppns_pkg::MOP_W1, ppns_pkg::MOP_W2: ww_r <= ww_r + AW'(prod_r);
        ppns_pkg::MOP_SQ_LL: num_r <= num_r + NW'(prod_r);
        ppns_pkg::MOP_SQ_HL: num_r <= num_r + (NW'(prod_r) << (HW + 1));
        ppns_pkg::MOP_SQ_HH: num_r <= num_r + (NW'(prod_r) << AW);
        default: ;
      endcase
    end
    if (cmd.fin) begin
      if (sts.d_le0) begin
        dist_r <= vv_r;
      end else if (sts.d_ge_m) begin
        dist_r <= ww_r;
      end else begin
        dist_r <= (q >= vv_r) ? '0 : vv_r - q;
      end
    end
    if (cmd.upd && (cmd.first || (dist_r < best_r))) begin
      best_r <= dist_r;
      bseg_r <= cmd.seg;
    end
    if (cmd.out_load) begin
      out_dist_r <= ppns_pkg::DIST_W'(best_r);
      out_seg_r  <= bseg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= ppns_pkg::MOP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      tag_r <= cmd.mop;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_dist  = out_dist_r;
  assign out_seg   = out_seg_r;

endmodule

// ===== src/point_polyline_nearest_segment.sv =====
// Nearest segment of a 3D polyline. A segment takes longer when its nearest point is an interior
// projection (36-step divider) than at a vertex end or on a zero-length segment, and a result
// waits longer while an earlier result is held. Input is ready again as the result goes valid; a
// vertex load does not stall input. The shared 19x19 multiplier and bit-serial divider set the rate.
// Reset (rst_n low, synchronous) clears control and sets vertex_count to 2; store undefined.
module point_polyline_nearest_segment #(
  parameter int MAX_VERTICES = ppns_pkg::MAX_VERTICES
) (
  input logic      clk,
  input logic      rst_n,
  ppns_in_if.sink  in_ch,
  ppns_out_if.source out_ch,
  ppns_cfg_if.sink cfg_ch
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [ppns_pkg::VERT_W-1:0]   ram_rdata;
  ppns_pkg::cmd_t                cmd;
  ppns_pkg::sts_t                sts;

  ppns_ram #(
    .WIDTH(ppns_pkg::VERT_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_ch.coord_x, in_ch.coord_y, in_ch.coord_z}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppns_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_mode          (in_ch.mode),
    .in_vertex_index  (in_ch.vertex_index),
    .in_ready         (in_ch.ready),
    .cfg_valid        (cfg_ch.valid),
    .cfg_vertex_count (cfg_ch.vertex_count),
    .cfg_ready        (cfg_ch.ready),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_raddr        (ram_raddr),
    .cmd              (cmd),
    .sts              (sts)
  );

  ppns_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (in_ch.coord_x),
    .in_y      (in_ch.coord_y),
    .in_z      (in_ch.coord_z),
    .ram_rdata (ram_rdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dist  (out_ch.min_sq_distance),
    .out_seg   (out_ch.seg_index)
  );

endmodule

// ===== src/ppns_chk.sv =====
// Port-level checks for point_polyline_nearest_segment, attached by bind.
// Depends on ppns_pkg.
module ppns_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_mode,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ppns_pkg::DIST_W-1:0]   out_dist,
  input logic [ppns_pkg::SEG_W-1:0]    out_seg
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_dist) && $stable(out_seg))
    else $error("result changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("query transaction did not hold off input");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("load transaction stalled input");

  a_query_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !$rose(out_valid))
    else $error("result appeared too soon after query");

endmodule

bind point_polyline_nearest_segment ppns_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_dist  (out_ch.min_sq_distance),
  .out_seg   (out_ch.seg_index)
);

// ===== tb/sv/tb_point_polyline_nearest_segment.sv =====
// Testbench for point_polyline_nearest_segment: loads polylines, queries points and
// checks distance and segment index against an in-bench exact-integer predictor.
// Depends on ppns_pkg, ppns_if and the block's RTL.
module tb_point_polyline_nearest_segment;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [ppns_pkg::DIST_W-1:0] sq_dist;
    logic [ppns_pkg::SEG_W-1:0]  seg;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppns_in_if  in_ch();
  ppns_out_if out_ch();
  ppns_cfg_if cfg_ch();

  point_polyline_nearest_segment dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  longint        polyline [ppns_pkg::MAX_VERTICES][3];
  int            vcount_model;
  nearest_t      nearest_q[$];
  int            errors = 0;
  longint        cycles = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = MODE_LOAD; in_ch.vertex_index = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0;
    cfg_ch.valid = 1'b0; cfg_ch.vertex_count = 7'd2;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR t=%0t %s", $realtime, what);
  endtask

  function automatic longint unsigned segment_sq_dist(longint p[3], int s);
    longint v, e, w, d, m, vv, ww;
    longint unsigned q;
    d = 0; m = 0; vv = 0; ww = 0;
    for (int c = 0; c < 3; c++) begin
      v = p[c] - polyline[s][c];
      e = polyline[s+1][c] - polyline[s][c];
      w = p[c] - polyline[s+1][c];
      d += v * e; m += e * e; vv += v * v; ww += w * w;
    end
    if (d <= 0) return vv;
    if (d >= m) return ww;
    q = 64'(($unsigned(128'(d)) * $unsigned(128'(d))) / $unsigned(128'(m)));
    if (q >= vv) return '0;
    return vv - q;
  endfunction

  function automatic nearest_t predict_nearest(longint p[3]);
    int n;
    longint unsigned best, dd;
    nearest_t r;
    n = vcount_model < 2 ? 2 :
        (vcount_model > ppns_pkg::MAX_VERTICES ? ppns_pkg::MAX_VERTICES : vcount_model);
    best = 0; r.seg = '0;
    for (int i = 0; i + 1 < n; i++) begin
      dd = segment_sq_dist(p, i);
      if (i == 0 || dd < best) begin
        best = dd; r.seg = ppns_pkg::SEG_W'(i);
      end
    end
    r.sq_dist = best[ppns_pkg::DIST_W-1:0];
    return r;
  endfunction

  // result checker with random stall
  initial begin
    int hold;
    nearest_t got, exp_r;
    @(posedge rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.sq_dist = out_ch.min_sq_distance;
      got.seg     = out_ch.seg_index;
      if (nearest_q.size() == 0) begin
        report("result with none expected");
      end else begin
        exp_r = nearest_q.pop_front();
        if (got.sq_dist !== exp_r.sq_dist)
          report($sformatf("distance got %0d want %0d", got.sq_dist, exp_r.sq_dist));
        if (got.seg !== exp_r.seg)
          report($sformatf("segment got %0d want %0d", got.seg, exp_r.seg));
      end
    end
  end

  task automatic send_item(input logic mode, input int idx, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    int gap;
    longint p[3];
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.mode <= mode;
    in_ch.vertex_index <= idx[ppns_pkg::IDX_W-1:0];
    in_ch.coord_x <= x; in_ch.coord_y <= y; in_ch.coord_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    p[0] = $signed(x); p[1] = $signed(y); p[2] = $signed(z);
    if (mode == MODE_LOAD) begin
      polyline[idx] = p;
    end else begin
      nearest_q.push_back(predict_nearest(p));
    end
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (nearest_q.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int n);
    cfg_ch.valid <= 1'b1; cfg_ch.vertex_count <= n[ppns_pkg::CNT_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    vcount_model = int'(n[ppns_pkg::CNT_W-1:0]);
  endtask

  function automatic logic [15:0] rand_coord(input int span);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic load_polyline(input int n, input int span);
    for (int i = 0; i < n; i++)
      send_item(MODE_LOAD, i, rand_coord(span), rand_coord(span), rand_coord(span));
  endtask

  task automatic test_directed();
    write_vertex_count(2);
    send_item(MODE_LOAD, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(MODE_LOAD, 1, 16'h0100, 16'h0000, 16'h0000);
    send_item(MODE_QUERY, 0, 16'hFF00, 16'h0000, 16'h0000);
    send_item(MODE_QUERY, 0, 16'h0300, 16'h0000, 16'h0000);
    send_item(MODE_QUERY, 0, 16'h0080, 16'h0100, 16'hFF00);
    send_item(MODE_QUERY, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(MODE_QUERY, 0, 16'h8000, 16'h8000, 16'h8000);
    send_item(MODE_LOAD, 1, 16'h0000, 16'h0000, 16'h0000);
    send_item(MODE_QUERY, 0, 16'h0123, 16'hFEDC, 16'h0042);
    send_item(MODE_LOAD, 0, 16'h8000, 16'h8000, 16'h8000);
    send_item(MODE_LOAD, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(MODE_QUERY, 0, 16'h0001, 16'hFFFF, 16'h0000);
    send_item(MODE_QUERY, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
    drain_and_settle();
    write_vertex_count(4);
    send_item(MODE_LOAD, 2, 16'h8000, 16'h8000, 16'h8000);
    send_item(MODE_LOAD, 3, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(MODE_QUERY, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(MODE_QUERY, 0, 16'h1234, 16'h5678, 16'h9ABC);
    drain_and_settle();
  endtask

  task automatic test_count_extremes();
    load_polyline(64, 32768);
    drain_and_settle();
    write_vertex_count(64);
    repeat (6) send_item(MODE_QUERY, $urandom_range(0, 63),
                         rand_coord(32768), rand_coord(32768), rand_coord(32768));
    drain_and_settle();
    write_vertex_count(0);
    repeat (3) send_item(MODE_QUERY, 0, rand_coord(4000), rand_coord(4000), rand_coord(4000));
    drain_and_settle();
    write_vertex_count(127);
    repeat (3) send_item(MODE_QUERY, 0, rand_coord(4000), rand_coord(4000), rand_coord(4000));
    drain_and_settle();
  endtask

  task automatic test_random();
    int n, span;
    for (int phase = 0; phase < 20; phase++) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
      write_vertex_count(n);
      span = ($urandom_range(0, 1) == 0) ? 1024 : 32768;
      load_polyline(n, span);
      repeat (12) begin
        if ($urandom_range(0, 9) == 0)
          send_item(MODE_LOAD, $urandom_range(0, n - 1),
                    rand_coord(span), rand_coord(span), rand_coord(span));
        else
          send_item(MODE_QUERY, $urandom_range(0, 63),
                    rand_coord(span), rand_coord(span), rand_coord(span));
      end
      drain_and_settle();
    end
  endtask

  initial begin
    vcount_model = 2;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_extremes();
    test_random();
    drain_and_settle();
    if (nearest_q.size() != 0) report("expected results left over");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
